// ----- rtl/fspe_pkg.sv -----
package fspe_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_START   = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NONE    = 2'd3
  } fspe_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_STEP,
    ST_ENTER,
    ST_MUL,
    ST_FIN,
    ST_EMIT
  } fspe_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic step;
    logic enter;
    logic mul;
    logic fin;
    logic emit;
  } fspe_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    fspe_cmd_t cmd;
    logic      adv_ok;
    logic      carry;
    logic      last_stage;
    logic      rem_zero;
  } fspe_status_t;

  localparam int PHASE_W = 16;
  localparam int LEVEL_W = 16;
  localparam int LEFT_W  = 8;
  localparam int ELAP_W  = 9;
  localparam int IDX_W   = 2;
  localparam int STOUT_W = 3;

endpackage

// ----- rtl/four_stage_phase_envelope.sv -----
// Four-stage phase envelope. Load transactions fill one stage's phase step,
// start phase and signed target; a start transaction arms the envelope; an
// advance transaction steps the 16-bit phase once per elapsed period until a
// carry moves it to the next stage. Every transaction returns one result.
// Sequence, accept to result valid: load, start and a rejected advance go from
// decode straight to emit. An advance makes its phase additions (one per cycle
// through the single phase adder; up to 65536), then a multiply and a level add
// when it ends without a carry, or a stage entry after a carry into a stage that
// is not the last. A result held back by out_ready holds the emit state before
// the next transaction. A new transaction is taken while the previous result
// still waits in the output register.
module four_stage_phase_envelope
  import fspe_pkg::*;
#(
  parameter int NUM_STAGES = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic [IDX_W-1:0]          in_stage_index,
  input  logic [PHASE_W-1:0]        in_step_size,
  input  logic [PHASE_W-1:0]        in_first_phase,
  input  logic signed [LEVEL_W-1:0] in_goal_level,
  input  logic                      in_skip_attack,
  input  logic                      in_silent,
  input  logic [ELAP_W-1:0]         in_elapsed,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_accepted,
  output logic signed [LEVEL_W-1:0] out_level,
  output logic [STOUT_W-1:0]        out_stage_now,
  output logic                      out_running,
  output logic                      out_stage_moved
);

  fspe_ctrl_t   ctl;
  fspe_status_t sts;

  fspe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  fspe_dp #(
    .NUM_STAGES (NUM_STAGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_command),
    .in_stage_index  (in_stage_index),
    .in_step_size    (in_step_size),
    .in_first_phase  (in_first_phase),
    .in_goal_level   (in_goal_level),
    .in_skip_attack  (in_skip_attack),
    .in_silent       (in_silent),
    .in_elapsed      (in_elapsed),
    .out_accepted    (out_accepted),
    .out_level       (out_level),
    .out_stage_now   (out_stage_now),
    .out_running     (out_running),
    .out_stage_moved (out_stage_moved)
  );

endmodule

// ----- rtl/fspe_ctrl.sv -----
module fspe_ctrl
  import fspe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  fspe_status_t sts,
  output fspe_ctrl_t   ctl
);

  fspe_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.cmd == CMD_ADVANCE && sts.adv_ok) state_nxt = ST_STEP;
        else state_nxt = ST_EMIT;
      end
      ST_STEP: begin
        priority if (sts.carry) state_nxt = sts.last_stage ? ST_EMIT : ST_ENTER;
        else if (sts.rem_zero) state_nxt = ST_MUL;
        else state_nxt = ST_STEP;
      end
      ST_ENTER: state_nxt = ST_EMIT;
      ST_MUL:   state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_DECODE: ctl.decode = 1'b1;
      ST_STEP:   ctl.step   = 1'b1;
      ST_ENTER:  ctl.enter  = 1'b1;
      ST_MUL:    ctl.mul    = 1'b1;
      ST_FIN:    ctl.fin    = 1'b1;
      ST_EMIT:   ctl.emit   = slot_free;
      default: ;
    endcase
    // result register frees on take, reloads on emit
    if (ctl.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/fspe_dp.sv -----
module fspe_dp
  import fspe_pkg::*;
#(
  parameter int NUM_STAGES = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fspe_ctrl_t                 ctl,
  output fspe_status_t               sts,
  input  logic [1:0]                 in_command,
  input  logic [IDX_W-1:0]           in_stage_index,
  input  logic [PHASE_W-1:0]         in_step_size,
  input  logic [PHASE_W-1:0]         in_first_phase,
  input  logic signed [LEVEL_W-1:0]  in_goal_level,
  input  logic                       in_skip_attack,
  input  logic                       in_silent,
  input  logic [ELAP_W-1:0]          in_elapsed,
  output logic                       out_accepted,
  output logic signed [LEVEL_W-1:0]  out_level,
  output logic [STOUT_W-1:0]         out_stage_now,
  output logic                       out_running,
  output logic                       out_stage_moved
);

  localparam int SW  = $clog2(NUM_STAGES + 1);
  localparam int IW  = $clog2(NUM_STAGES);
  localparam int CMPW = (IW > IDX_W) ? IW : IDX_W;

  // captured transaction
  fspe_cmd_t          cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [PHASE_W-1:0] step_r;
  logic [PHASE_W-1:0] fphase_r;
  logic [LEVEL_W-1:0] goal_r;
  logic               skip_r;
  logic               silent_r;
  logic [ELAP_W-1:0]  elapsed_r;

  // stage parameter tables
  logic [PHASE_W-1:0] rate_tbl_r   [NUM_STAGES];
  logic [PHASE_W-1:0] phase_tbl_r  [NUM_STAGES];
  logic [LEVEL_W-1:0] target_tbl_r [NUM_STAGES];

  // envelope state
  logic [SW-1:0]      stage_r, stage_nxt;
  logic               active_r, active_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [LEVEL_W-1:0] base_r, base_nxt;
  logic [LEVEL_W-1:0] span_r, span_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;

  logic [15:0]        remain_r, remain_nxt;
  logic               acc_r, acc_nxt;
  logic               moved_r, moved_nxt;
  logic signed [32:0] prod_r;

  logic [IW-1:0]      cur_idx;
  logic [IW-1:0]      start_idx;
  logic [PHASE_W:0]   sum;
  logic [LEVEL_W-1:0] end_lvl;
  logic [LEVEL_W-1:0] start_base;
  logic [LEFT_W-1:0]  count_m1;

  assign cur_idx    = stage_r[IW-1:0];
  assign start_idx  = IW'(skip_r);
  assign sum        = {1'b0, phase_r} + {1'b0, rate_tbl_r[cur_idx]};
  assign end_lvl    = base_r + span_r;
  assign start_base = skip_r ? target_tbl_r[0] : '0;
  assign count_m1   = elapsed_r[LEFT_W-1:0] - LEFT_W'(1);

  assign sts.cmd        = cmd_r;
  assign sts.adv_ok     = active_r && (stage_r < SW'(NUM_STAGES)) && (elapsed_r != '0);
  assign sts.carry      = sum[PHASE_W];
  assign sts.last_stage = (stage_r == SW'(NUM_STAGES - 1));
  assign sts.rem_zero   = (remain_r == '0);

  always_comb begin
    stage_nxt  = stage_r;
    active_nxt = active_r;
    phase_nxt  = phase_r;
    base_nxt   = base_r;
    span_nxt   = span_r;
    lvl_nxt    = lvl_r;
    left_nxt   = left_r;
    remain_nxt = remain_r;
    acc_nxt    = acc_r;
    moved_nxt  = moved_r;

    priority if (ctl.capture) begin
      acc_nxt   = 1'b0;
      moved_nxt = 1'b0;
    end else if (ctl.decode) begin
      unique case (cmd_r)
        CMD_START: begin
          left_nxt = '0;
          if (silent_r) begin
            stage_nxt  = SW'(NUM_STAGES);
            active_nxt = 1'b0;
            phase_nxt  = '0;
            base_nxt   = '0;
            span_nxt   = '0;
            lvl_nxt    = '0;
          end else begin
            stage_nxt  = SW'(skip_r);
            base_nxt   = start_base;
            lvl_nxt    = start_base;
            span_nxt   = target_tbl_r[start_idx] - start_base;
            phase_nxt  = phase_tbl_r[start_idx];
            active_nxt = 1'b1;
          end
        end
        CMD_ADVANCE: begin
          if (sts.adv_ok) begin
            acc_nxt    = 1'b1;
            // saved remainder plus sign-extended (elapsed[7:0] - 1)
            remain_nxt = {8'b0, left_r} + {{8{count_m1[LEFT_W-1]}}, count_m1};
          end
        end
        CMD_LOAD, CMD_NONE: ;
        default: ;
      endcase
    end else if (ctl.step) begin
      if (sum[PHASE_W]) begin
        left_nxt  = remain_r[LEFT_W-1:0];
        stage_nxt = stage_r + SW'(1);
        moved_nxt = 1'b1;
        lvl_nxt   = end_lvl;
        if (sts.last_stage) begin
          phase_nxt  = '0;
          active_nxt = 1'b0;
        end else begin
          base_nxt = end_lvl;
        end
      end else begin
        phase_nxt  = sum[PHASE_W-1:0];
        remain_nxt = remain_r - 16'd1;
        if (remain_r == '0) left_nxt = '0;
      end
    end else if (ctl.enter) begin
      span_nxt  = target_tbl_r[cur_idx] - base_r;
      phase_nxt = phase_tbl_r[cur_idx];
    end else if (ctl.fin) begin
      // floor(span * phase / 65536)
      lvl_nxt = base_r + prod_r[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= SW'(NUM_STAGES);
      active_r <= 1'b0;
      phase_r  <= '0;
      base_r   <= '0;
      span_r   <= '0;
      lvl_r    <= '0;
      left_r   <= '0;
    end else begin
      stage_r  <= stage_nxt;
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      base_r   <= base_nxt;
      span_r   <= span_nxt;
      lvl_r    <= lvl_nxt;
      left_r   <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    acc_r    <= acc_nxt;
    moved_r  <= moved_nxt;
    if (ctl.capture) begin
      cmd_r     <= fspe_cmd_t'(in_command);
      idx_r     <= in_stage_index;
      step_r    <= in_step_size;
      fphase_r  <= in_first_phase;
      goal_r    <= in_goal_level;
      skip_r    <= in_skip_attack;
      silent_r  <= in_silent;
      elapsed_r <= in_elapsed;
    end
    if (ctl.mul) begin
      prod_r <= $signed(span_r) * $signed({1'b0, phase_r});
    end
    if (ctl.emit) begin
      out_accepted    <= acc_r;
      out_level       <= lvl_r;
      out_stage_now   <= STOUT_W'(stage_r);
      out_running     <= active_r;
      out_stage_moved <= moved_r;
    end
  end

  // loads to an index past the last stage are dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (ctl.decode && cmd_r == CMD_LOAD && CMPW'(idx_r) == CMPW'(i)) begin
        rate_tbl_r[i]   <= step_r;
        phase_tbl_r[i]  <= fphase_r;
        target_tbl_r[i] <= goal_r;
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import fspe_pkg::*;

  localparam int NUM_STAGES  = 4;
  localparam int NUM_RANDOM  = 725;
  localparam int HOLD_CYCLES = 400;
  localparam int HEAVY_ADDS  = 400;
  localparam int SCRIPT_LEN  = 26;

  typedef struct packed {
    fspe_cmd_t                 cmd;
    logic [IDX_W-1:0]          idx;
    logic [PHASE_W-1:0]        step;
    logic [PHASE_W-1:0]        fphase;
    logic signed [LEVEL_W-1:0] goal;
    logic                      skip;
    logic                      silent;
    logic [ELAP_W-1:0]         elapsed;
  } env_txn_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [LEVEL_W-1:0] level;
    logic [STOUT_W-1:0]        stage;
    logic                      running;
    logic                      moved;
  } env_out_t;

  typedef struct packed {
    logic [STOUT_W-1:0]           stage;
    logic                         active;
    logic [PHASE_W-1:0]           phase;
    logic [LEVEL_W-1:0]           base;
    logic [LEVEL_W-1:0]           span;
    logic [LEVEL_W-1:0]           level;
    logic [LEFT_W-1:0]            leftover;
    logic [3:0][PHASE_W-1:0]      rate;
    logic [3:0][PHASE_W-1:0]      sphase;
    logic [3:0][LEVEL_W-1:0]      target;
  } env_regs_t;

  typedef struct packed {
    env_txn_t txn;
    logic     typed;
    env_out_t want;
  } script_row_t;

  localparam env_out_t OUT_IDLE = '{1'b0, 16'sh0000, 3'd4, 1'b0, 1'b0};

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                in_command;
  logic [IDX_W-1:0]          in_stage_index;
  logic [PHASE_W-1:0]        in_step_size;
  logic [PHASE_W-1:0]        in_first_phase;
  logic signed [LEVEL_W-1:0] in_goal_level;
  logic                      in_skip_attack;
  logic                      in_silent;
  logic [ELAP_W-1:0]         in_elapsed;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_accepted;
  logic signed [LEVEL_W-1:0] out_level;
  logic [STOUT_W-1:0]        out_stage_now;
  logic                      out_running;
  logic                      out_stage_moved;

  env_out_t pending_results[$];
  int       fail_count = 0;
  int       got_count = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd1},   1'b1, OUT_IDLE},
    '{'{CMD_START,   2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b1, 1'b1, 9'd0},   1'b1, OUT_IDLE},
    '{'{CMD_NONE,    2'd3, 16'hFFFF, 16'hFFFF, 16'shFFFF, 1'b1, 1'b0, 9'h1FF}, 1'b1, OUT_IDLE},
    '{'{CMD_LOAD,    2'd0, 16'h0100, 16'h0000, 16'sh7FFF, 1'b0, 1'b0, 9'd0},   1'b1, OUT_IDLE},
    '{'{CMD_LOAD,    2'd1, 16'hFFFF, 16'hFFFF, 16'sh8000, 1'b0, 1'b0, 9'd0},   1'b1, OUT_IDLE},
    '{'{CMD_LOAD,    2'd2, 16'h0000, 16'h1234, 16'sh0000, 1'b0, 1'b0, 9'd0},   1'b1, OUT_IDLE},
    '{'{CMD_LOAD,    2'd3, 16'h0001, 16'h0000, 16'sh5555, 1'b0, 1'b0, 9'd0},   1'b1, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd0},   1'b1, OUT_IDLE},
    '{'{CMD_START,   2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd0},   1'b1,
      '{1'b0, 16'sh0000, 3'd0, 1'b1, 1'b0}},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd0},   1'b1,
      '{1'b0, 16'sh0000, 3'd0, 1'b1, 1'b0}},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd1},   1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd64},  1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd257}, 1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd300}, 1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd256}, 1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd1},   1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd3},   1'b0, OUT_IDLE},
    // zero step with a wrapped count: a full 65536-step pass with no carry
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd256}, 1'b0, OUT_IDLE},
    '{'{CMD_START,   2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b1, 1'b0, 9'd0},   1'b1,
      '{1'b0, 16'sh7FFF, 3'd1, 1'b1, 1'b0}},
    '{'{CMD_LOAD,    2'd2, 16'h8000, 16'h1234, 16'sh0000, 1'b0, 1'b0, 9'd0},   1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd1},   1'b0, OUT_IDLE},
    '{'{CMD_LOAD,    2'd3, 16'hC000, 16'h0000, 16'sh5555, 1'b0, 1'b0, 9'd0},   1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd4},   1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd511}, 1'b0, OUT_IDLE},
    '{'{CMD_ADVANCE, 2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b0, 9'd5},   1'b1,
      '{1'b1, 16'sh5555, 3'd4, 1'b0, 1'b1}},
    '{'{CMD_START,   2'd0, 16'h0000, 16'h0000, 16'sh0000, 1'b0, 1'b1, 9'd0},   1'b1, OUT_IDLE}
  };

  four_stage_phase_envelope #(
    .NUM_STAGES(NUM_STAGES)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_stage_index (in_stage_index),
    .in_step_size   (in_step_size),
    .in_first_phase (in_first_phase),
    .in_goal_level  (in_goal_level),
    .in_skip_attack (in_skip_attack),
    .in_silent      (in_silent),
    .in_elapsed     (in_elapsed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_level      (out_level),
    .out_stage_now  (out_stage_now),
    .out_running    (out_running),
    .out_stage_moved(out_stage_moved)
  );

  always #1 clk = ~clk;

  // Next envelope state and the result for one transaction; adds counts phase additions.
  function automatic void envelope_update(input env_regs_t s_in, input env_txn_t t,
                                          output env_regs_t s, output env_out_t r,
                                          output int adds);
    logic [7:0]         c;
    logic [PHASE_W-1:0] remaining;
    logic [PHASE_W-1:0] working;
    logic [PHASE_W-1:0] nxt;
    logic [PHASE_W-1:0] inc;
    logic [LEVEL_W-1:0] fin;
    longint             prod;
    bit                 done;
    s = s_in;
    r = '0;
    adds = 0;
    case (t.cmd)
      CMD_LOAD: begin
        s.rate[t.idx] = t.step;
        s.sphase[t.idx] = t.fphase;
        s.target[t.idx] = t.goal;
      end
      CMD_START: begin
        s.leftover = '0;
        if (t.silent) begin
          s.stage = 3'(NUM_STAGES);
          s.active = 1'b0;
          s.phase = '0;
          s.base = '0;
          s.span = '0;
          s.level = '0;
        end else begin
          s.stage = t.skip ? 3'd1 : 3'd0;
          s.base = t.skip ? s.target[0] : '0;
          s.level = s.base;
          s.span = s.target[s.stage[1:0]] - s.base;
          s.phase = s.sphase[s.stage[1:0]];
          s.active = 1'b1;
        end
      end
      CMD_ADVANCE: begin
        if (s.active && s.stage < NUM_STAGES && t.elapsed != 0) begin
          c = 8'(t.elapsed - 9'd1);
          // count is the saved remainder plus elapsed-1 taken as a signed byte
          remaining = {8'd0, s.leftover} + {{8{c[7]}}, c};
          working = s.phase;
          inc = s.rate[s.stage[1:0]];
          r.accepted = 1'b1;
          done = 1'b0;
          while (!done) begin
            nxt = working + inc;
            adds++;
            if (nxt < working) begin
              fin = s.base + s.span;
              s.leftover = remaining[7:0];
              s.stage = s.stage + 3'd1;
              r.moved = 1'b1;
              if (s.stage >= NUM_STAGES) begin
                s.level = fin;
                s.phase = '0;
                s.active = 1'b0;
              end else begin
                s.base = fin;
                s.level = fin;
                s.span = s.target[s.stage[1:0]] - s.base;
                s.phase = s.sphase[s.stage[1:0]];
              end
              done = 1'b1;
            end else begin
              working = nxt;
              remaining = remaining - 16'd1;
              if (remaining == 16'hFFFF) begin
                s.phase = working;
                s.leftover = '0;
                prod = longint'($signed(s.span)) * longint'(working);
                s.level = s.base + 16'(prod >>> 16);
                done = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.level = s.level;
    r.stage = s.stage;
    r.running = s.active;
  endfunction

  function automatic int pick_gap(input int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_txn(input env_txn_t t, input env_out_t want, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command = t.cmd;
    in_stage_index = t.idx;
    in_step_size = t.step;
    in_first_phase = t.fphase;
    in_goal_level = t.goal;
    in_skip_attack = t.skip;
    in_silent = t.silent;
    in_elapsed = t.elapsed;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(want);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    int  gap_left;
    int  hold_left;
    bit  held;
    gap_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && got_count >= 150) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready = 1'b0;
        gap_left--;
      end else begin
        out_ready = 1'b1;
        gap_left = pick_gap(((got_count / 100) % 3 == 1) ? 0 : 30);
      end
    end
  end

  always @(posedge clk) begin : check_results
    env_out_t want;
    if (rst_n && out_valid && out_ready) begin
      got_count <= got_count + 1;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_accepted);
          fail_count++;
        end
        if (out_level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_level);
          fail_count++;
        end
        if (out_stage_now !== want.stage) begin
          $error("stage_now: expected %0d, got %0d", want.stage, out_stage_now);
          fail_count++;
        end
        if (out_running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, out_running);
          fail_count++;
        end
        if (out_stage_moved !== want.moved) begin
          $error("stage_moved: expected %0d, got %0d", want.moved, out_stage_moved);
          fail_count++;
        end
      end
    end
  end

  initial begin
    env_regs_t env_now;
    env_regs_t env_after;
    env_out_t  pred;
    env_txn_t  t;
    int        adds;
    int        counted;
    int        heavy_left;
    int        pick;
    bit        paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0;
    in_stage_index = '0;
    in_step_size = '0;
    in_first_phase = '0;
    in_goal_level = '0;
    in_skip_attack = 1'b0;
    in_silent = 1'b0;
    in_elapsed = '0;
    env_now = '0;
    env_now.stage = 3'(NUM_STAGES);
    counted = 0;
    heavy_left = 4;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      envelope_update(env_now, script[i].txn, env_after, pred, adds);
      send_txn(script[i].txn, script[i].typed ? script[i].want : pred, pick_gap(20));
      env_now = env_after;
    end

    while (counted < NUM_RANDOM) begin
      t = '0;
      pick = $urandom_range(0, 99);
      if (pick < 12) t.cmd = CMD_LOAD;
      else if (pick < 22) t.cmd = CMD_START;
      else if (pick < 96) t.cmd = CMD_ADVANCE;
      else t.cmd = CMD_NONE;
      // an idle envelope mostly gets re-armed so advances have something to do
      if (t.cmd == CMD_ADVANCE && !env_now.active && $urandom_range(0, 3) != 0)
        t.cmd = CMD_START;
      t.idx = 2'($urandom);
      case ($urandom_range(0, 5))
        0: t.step = 16'($urandom_range(1, 255));
        1: t.step = 16'($urandom_range(256, 4095));
        2: t.step = 16'($urandom_range(4096, 32767));
        3: t.step = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: t.step = 16'($urandom);
      endcase
      if ($urandom_range(0, 7) == 0) t.fphase = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else t.fphase = 16'($urandom);
      if ($urandom_range(0, 7) == 0) t.goal = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else t.goal = 16'($urandom);
      t.skip = 1'($urandom);
      t.silent = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) t.elapsed = '0;
      else if (pick < 70) t.elapsed = 9'($urandom_range(1, 16));
      else if (pick < 85) t.elapsed = 9'($urandom_range(17, 128));
      else if (pick < 95) t.elapsed = 9'($urandom_range(129, 256));
      else t.elapsed = 9'($urandom_range(257, 511));
      envelope_update(env_now, t, env_after, pred, adds);
      // advances of over HEAVY_ADDS phase additions are kept four times, then get a short elapsed
      if (adds > HEAVY_ADDS) begin
        if (heavy_left > 0) begin
          heavy_left--;
        end else begin
          t.elapsed = 9'($urandom_range(1, 8));
          envelope_update(env_now, t, env_after, pred, adds);
        end
      end
      if (counted == 300 && !paused) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_txn(t, pred, pick_gap(((counted / 100) % 3 == 2) ? 0 : 35));
      env_now = env_after;
      counted++;
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS four_stage_phase_envelope");
    end else begin
      $display("FAIL four_stage_phase_envelope");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL four_stage_phase_envelope");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fspe_pkg.sv
rtl/fspe_ctrl.sv
rtl/fspe_dp.sv
rtl/four_stage_phase_envelope.sv
tb/tb.sv
